@@ sv/zs_pkg.sv @@
// ============================================================================
// zs_pkg: shared types and constants for the thinning sub-pass core
// Holds register indexes, rule limits, the stage tag and the deletion test.
// ============================================================================
package zs_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_SUBPASS_SELECT = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;

   // Row position runs to image_height + 1, so 13 bits suffice.
   localparam int ROW_W      = 13;
   localparam int MAX_HEIGHT = 4096;

   // Rule limits on transition count and neighbour sum
   localparam logic [3:0] TRANS_TARGET = 4'd1;
   localparam logic [3:0] SUM_MIN      = 4'd2;
   localparam logic [3:0] SUM_MAX      = 4'd6;

   // Per-item control carried from the position tracker to the window stage
   typedef struct packed {
      logic pix;       // pixel value, flush forced to background
      logic emit;      // this item produces a result
      logic interior;  // window centre is not a border position
      logic fend;      // result closes the frame
   } zs_tag_type;

   // Window layout: bits 0..2 right column, 3..5 centre, 6..8 left;
   // the lowest bit of a column is the top row.
   function automatic logic zs_deletable(input logic [8:0] win, input logic sel);
      logic [7:0] n;
      logic [3:0] a;
      logic [3:0] b;
      logic       m1;
      logic       m2;
      n = {win[6], win[7], win[8], win[5], win[2], win[1], win[0], win[3]};
      a = 4'd0;
      b = 4'd0;
      for (int k = 0; k < 8; k++) begin
         b = b + 4'(n[k]);
         if (!n[k] && n[(k + 1) % 8]) begin
            a = a + 4'd1;
         end
      end
      if (!sel) begin
         m1 = n[0] & n[2] & n[4];
         m2 = n[2] & n[4] & n[6];
      end else begin
         m1 = n[0] & n[2] & n[6];
         m2 = n[0] & n[4] & n[6];
      end
      return (a == TRANS_TARGET) && (b >= SUM_MIN) && (b <= SUM_MAX) && !m1 && !m2;
   endfunction

endpackage

@@ sv/zs_line_mem.sv @@
// ============================================================================
// zs_line_mem: two-line store
// One synchronous memory holding the upper and middle line bit per column,
// with a write-to-read bypass for same-address accesses in one cycle.
// ============================================================================
module zs_line_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [1:0]    wr_data,   // [0] upper line, [1] middle line
   output logic [1:0]    rd_data    // [0] upper line, [1] middle line
);

   logic [1:0] line_ff [DEPTH];
   logic [1:0] rd_data_ff;
   logic       byp_ff;
   logic [1:0] byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= line_ff[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_data_ff;

endmodule

@@ sv/zs_pos_track.sv @@
// ============================================================================
// zs_pos_track: frame position tracker
// Counts column and row of each incoming item and tags it with its role.
// ============================================================================
module zs_pos_track #(
   parameter int CW = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    pixel_in,
   input  logic                    flush,
   input  logic [CW:0]             width_eff,
   input  logic [zs_pkg::ROW_W-1:0] height_eff,
   output logic [CW-1:0]           column,
   output zs_pkg::zs_tag_type      tag
);
   import zs_pkg::*;

   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW:0]      col_next;
   logic             wrap;

   always_comb begin
      col_next     = {1'b0, col_ff} + 1'b1;
      wrap         = col_next >= width_eff;
      tag.pix      = pixel_in & ~flush;
      tag.emit     = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ff != '0);
      // a column at or past the current width counts as border
      tag.interior = (col_ff >= CW'(2)) && ({1'b0, col_ff} < width_eff)
                     && (row_ff >= ROW_W'(2)) && (row_ff < height_eff);
      tag.fend     = tag.emit && (col_ff == '0) && (row_ff >= height_eff + 1'b1);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (tag.fend) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   assign column = col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ sv/zs_window_eval.sv @@
// ============================================================================
// zs_window_eval: window stage and result register
// Completes the line-store read-modify-write, shifts the 3x3 window, applies
// the sub-pass rules and holds the result until the downstream transfer.
// ============================================================================
module zs_window_eval #(
   parameter int CW = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [CW-1:0]      column,
   input  zs_pkg::zs_tag_type tag,
   input  logic               subpass_sel,
   input  logic [1:0]         rd_data,
   output logic               take_ready,
   output logic               wr_en,
   output logic [CW-1:0]      wr_addr,
   output logic [1:0]         wr_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic               out_pixel,
   output logic               out_removed,
   output logic               out_frame_end,
   output logic               out_frame_changed
);
   import zs_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   zs_tag_type    s1_tag_ff;
   logic [CW-1:0] s1_col_ff;
   logic [8:0]    win_ff, win_in;
   logic          any_ff, any_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          pix_ff, rem_ff, fend_ff, chg_ff;
   logic          s1_go;
   logic          rem;
   logic          centre;

   always_comb begin
      s1_go       = s1_valid_ff && (!s1_tag_ff.emit || !rsp_valid_ff || out_ready);
      take_ready  = !s1_valid_ff || s1_go;
      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

      // Upper takes the old middle bit, middle takes the new pixel
      wr_en   = s1_go;
      wr_addr = s1_col_ff;
      wr_data = {s1_tag_ff.pix, rd_data[1]};

      win_in = {win_ff[5:0], s1_tag_ff.pix, rd_data[1], rd_data[0]};
      if (!s1_go) begin
         win_in = win_ff;
      end
      centre = win_in[4];
      rem    = centre && s1_tag_ff.interior && zs_deletable(win_in, subpass_sel);

      any_in = any_ff;
      if (s1_go && s1_tag_ff.emit) begin
         any_in = s1_tag_ff.fend ? 1'b0 : (any_ff | rem);
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_tag_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         win_ff       <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         win_ff       <= win_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff <= tag;
         s1_col_ff <= column;
      end
      if (s1_go && s1_tag_ff.emit) begin
         pix_ff  <= centre & ~rem;
         rem_ff  <= rem;
         fend_ff <= s1_tag_ff.fend;
         chg_ff  <= s1_tag_ff.fend & (any_ff | rem);
      end
   end

   assign out_valid         = rsp_valid_ff;
   assign out_pixel         = pix_ff;
   assign out_removed       = rem_ff;
   assign out_frame_end     = fend_ff;
   assign out_frame_changed = chg_ff;

endmodule

@@ sv/zhang_suen_thinning_subpass_core.sv @@
// ============================================================================
// zhang_suen_thinning_subpass_core: one Zhang-Suen thinning sub-pass
// Streams a binary image through a 3x3 window and clears deletable pixels.
// ============================================================================
// The core takes one pixel per clock and gives one result per clock once the
// window has filled, while rsp_tready stays high. Every input transfer, flush
// or not, advances the frame position; results lag the input by image_width+1
// transfers, so follow each frame with image_width+1 flush transfers.
// Throughput is set by the single line-store memory, which is read when a
// pixel arrives and written back as the pixel leaves the window stage; the
// one same-address case (the first pixel after a frame end) is served by a
// bypass. Border pixels pass through unchanged. The result carrying tlast
// closes the frame and reports in frame_changed whether any pixel was removed.
// The line store has no clearing pass after reset: stale entries only ever
// meet border positions. Write configuration only while the core is idle.
// ============================================================================
module zhang_suen_thinning_subpass_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   // input pixel stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [0] pixel_in, [7:1] zero
   input  logic                           req_tuser,   // [0] flush
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [0] pixel_out, [1] removed,
                                                       // [2] frame_changed, [7:3] zero
   output logic                           rsp_tlast,   // frame_end
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [zs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [zs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import zs_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (CW + 1 > CFG_WIDTH_W) ? CW + 1 : CFG_WIDTH_W;

   logic [CFG_WIDTH_W-1:0]  width_cfg_ff;
   logic [CFG_HEIGHT_W-1:0] height_cfg_ff;
   logic                    sel_ff;

   logic [CMPW-1:0]  width_ext;
   logic [CW:0]      width_eff;
   logic [ROW_W-1:0] height_eff;

   logic          req_xfer;
   logic          take_ready;
   logic [CW-1:0] column;
   zs_tag_type    tag;
   logic [1:0]    rd_data;
   logic          wr_en;
   logic [CW-1:0] wr_addr;
   logic [1:0]    wr_data;
   logic          out_pixel, out_removed, out_changed;

   // Configuration: always ready, ignore unknown indexes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= CFG_WIDTH_W'(1024);
         height_cfg_ff <= CFG_HEIGHT_W'(1024);
         sel_ff        <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:    width_cfg_ff  <= csr_data[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:   height_cfg_ff <= csr_data[CFG_HEIGHT_W-1:0];
            CSR_SUBPASS_SELECT: sel_ff        <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Saturate the frame size to the supported range
   always_comb begin
      width_ext = CMPW'(width_cfg_ff);
      if (width_ext < CMPW'(3)) begin
         width_eff = (CW + 1)'(3);
      end else if (width_ext > CMPW'(MAX_WIDTH)) begin
         width_eff = (CW + 1)'(MAX_WIDTH);
      end else begin
         width_eff = width_ext[CW:0];
      end
      if (height_cfg_ff < CFG_HEIGHT_W'(3)) begin
         height_eff = ROW_W'(3);
      end else if (height_cfg_ff > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
         height_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_cfg_ff;
      end
   end

   // Accept a pixel whenever the window stage can advance
   assign req_tready = take_ready;
   assign req_xfer   = req_tvalid && take_ready;

   zs_pos_track #(
      .CW(CW)
   ) u_pos (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_xfer),
      .pixel_in  (req_tdata[0]),
      .flush     (req_tuser),
      .width_eff (width_eff),
      .height_eff(height_eff),
      .column    (column),
      .tag       (tag)
   );

   // Read the column's line bits as the pixel arrives
   zs_line_mem #(
      .DEPTH(MAX_WIDTH),
      .AW   (CW)
   ) u_mem (
      .clock  (clock),
      .rd_en  (req_xfer),
      .rd_addr(column),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   // Write back, shift the window, decide, hold the result
   zs_window_eval #(
      .CW(CW)
   ) u_eval (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_xfer),
      .column           (column),
      .tag              (tag),
      .subpass_sel      (sel_ff),
      .rd_data          (rd_data),
      .take_ready       (take_ready),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_pixel        (out_pixel),
      .out_removed      (out_removed),
      .out_frame_end    (rsp_tlast),
      .out_frame_changed(out_changed)
   );

   assign rsp_tdata = {5'b0, out_changed, out_removed, out_pixel};

endmodule

@@ sim/zs_subpass_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// zs_subpass_checker: result predictor and comparator for the thinning core
// Watches the pixel, result and register channels, predicts every thinned
// pixel from a private copy of the line stores and window, and compares the
// results in order.
// ============================================================================
module zs_subpass_checker #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [7:0]                     rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [zs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [zs_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                             mismatch_count,
   output int                             results_due,
   output int                             results_checked,
   output int                             pixels_removed,
   output int                             frames_closed
);
   import zs_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic pixel_out;
      logic removed;
      logic frame_end;
      logic frame_changed;
   } thinned_pixel_type;

   logic [CFG_WIDTH_W-1:0]  width_reg;
   logic [CFG_HEIGHT_W-1:0] height_reg;
   logic                    rule_reg;

   logic       upper_store  [MAX_WIDTH];
   logic       middle_store [MAX_WIDTH];
   logic [8:0] window;
   int         col_pos;
   int         row_pos;
   logic       any_erased;

   thinned_pixel_type thinned_due [$];

   function automatic int clamp_dim(input int raw, input int hi);
      if (raw < 3) return 3;
      if (raw > hi) return hi;
      return raw;
   endfunction

   // Window: bits 2:0 newest (right) column, 5:3 centre, 8:6 left; top row lowest.
   function automatic logic can_erase(input logic [8:0] win, input logic second_rule);
      logic       p2, p3, p4, p5, p6, p7, p8, p9;
      logic [7:0] ring;
      logic [7:0] ahead;
      int         rises;
      int         count;
      p2 = win[3];
      p3 = win[0];
      p4 = win[1];
      p5 = win[2];
      p6 = win[5];
      p7 = win[8];
      p8 = win[7];
      p9 = win[6];
      ring  = {p9, p8, p7, p6, p5, p4, p3, p2};
      ahead = {ring[0], ring[7:1]};
      rises = $countones(~ring & ahead);
      count = $countones(ring);
      if (rises != int'(TRANS_TARGET) || count < int'(SUM_MIN) || count > int'(SUM_MAX)) begin
         return 1'b0;
      end
      if (!second_rule) begin
         return !(p2 & p4 & p6) && !(p4 & p6 & p8);
      end
      return !(p2 & p4 & p8) && !(p2 & p6 & p8);
   endfunction

   task automatic predict_thinned_pixel(input logic pix_raw, input logic is_flush);
      int                w;
      int                h;
      int                ci;
      int                ri;
      int                ro;
      int                co;
      logic              pix;
      logic              up;
      logic              mid;
      logic              emit;
      logic              fend;
      logic              erase;
      thinned_pixel_type due;
      w   = clamp_dim(int'(width_reg), MAX_WIDTH);
      h   = clamp_dim(int'(height_reg), MAX_HEIGHT);
      pix = pix_raw & ~is_flush;
      ci  = col_pos;
      ri  = row_pos;
      up  = 1'b0;
      mid = 1'b0;
      if (ci < MAX_WIDTH) begin
         up               = upper_store[ci];
         mid              = middle_store[ci];
         upper_store[ci]  = mid;
         middle_store[ci] = pix;
      end
      window = {window[5:0], pix, mid, up};

      emit = (ri >= 2) || (ri == 1 && ci >= 1);
      if (ci >= 1) begin
         ro = ri - 1;
         co = ci - 1;
      end else begin
         ro = (ri >= 2) ? ri - 2 : 0;
         co = w - 1;
      end
      fend = emit && ci == 0 && ri >= h + 1;

      if (ci + 1 >= w) begin
         col_pos = 0;
         row_pos = ri + 1;
      end else begin
         col_pos = ci + 1;
      end

      if (emit) begin
         erase = window[4] && ro != 0 && ro < h - 1 && co != 0 && co < w - 1
                 && can_erase(window, rule_reg);
         if (erase) any_erased = 1'b1;
         due.pixel_out     = window[4] & ~erase;
         due.removed       = erase;
         due.frame_end     = fend;
         due.frame_changed = fend & any_erased;
         thinned_due.insert(thinned_due.size(), due);
         if (fend) begin
            col_pos    = 0;
            row_pos    = 0;
            any_erased = 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin : watch_channels
      thinned_pixel_type got;
      thinned_pixel_type due;
      if (reset) begin
         width_reg  = 11'd1024;
         height_reg = 13'd1024;
         rule_reg   = 1'b0;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_store[i]  = 1'b0;
            middle_store[i] = 1'b0;
         end
         window          = '0;
         col_pos         = 0;
         row_pos         = 0;
         any_erased      = 1'b0;
         thinned_due.delete();
         mismatch_count  = 0;
         results_due     = 0;
         results_checked = 0;
         pixels_removed  = 0;
         frames_closed   = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:    width_reg  = csr_data[CFG_WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT:   height_reg = csr_data[CFG_HEIGHT_W-1:0];
               CSR_SUBPASS_SELECT: rule_reg   = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_thinned_pixel(req_tdata[0], req_tuser);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[1], rsp_tlast, rsp_tdata[2]};
            if (thinned_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("unexpected result: pix=%b rem=%b end=%b chg=%b",
                           got.pixel_out, got.removed, got.frame_end, got.frame_changed);
               end
            end else begin
               due = thinned_due.pop_front();
               results_checked++;
               if (due.removed) pixels_removed++;
               if (due.frame_end) frames_closed++;
               if (got !== due || rsp_tdata[7:3] !== 5'd0) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("result %0d mismatch: expected pix=%b rem=%b end=%b chg=%b, %s",
                              results_checked, due.pixel_out, due.removed, due.frame_end,
                              due.frame_changed, "actual below");
                     $display("   actual pix=%b rem=%b end=%b chg=%b pad=%b",
                              got.pixel_out, got.removed, got.frame_end, got.frame_changed,
                              rsp_tdata[7:3]);
                  end
               end
            end
         end
         results_due = thinned_due.size();
      end
   end

endmodule

@@ sim/zhang_suen_thinning_subpass_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// zhang_suen_thinning_subpass_core_tb: stimulus and verdict for the core
// Streams binary frames with trailing flush transfers through the core under
// random idling on both sides, rewrites the registers between frames, and
// relies on the checker for prediction and comparison.
// ============================================================================
module zhang_suen_thinning_subpass_core_tb;
   import zs_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 10;
   localparam int FRAME_MAX_WIDTH = 1024;
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int DRAIN_LIMIT     = 50_000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_ITEMS    = 240;
   localparam int MAX_GAP         = 16;
   localparam int HOLD_AT         = 60;    // result count that triggers the long hold-off
   localparam int LONG_HOLD       = 400;   // cycles of receiver hold-off

   // Unmapped register index: a write must leave the configuration untouched.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // Receiver pacing
   logic rsp_taken     = 1'b0;
   int   rsp_transfers = 0;
   int   rsp_gap       = 0;
   bit   rsp_idle_on   = 1'b1;

   // Sender pacing; quiet_mode turns idling off on both sides for one frame
   bit   sender_idle_on = 1'b1;
   bit   quiet_mode     = 1'b0;

   int   cycle_count     = 0;
   int   in_transfers    = 0;
   int   flush_transfers = 0;
   int   frames_sent     = 0;
   int   random_items    = 0;

   int   mismatches;
   int   results_due;
   int   results_checked;
   int   pixels_removed;
   int   frames_closed;

   zhang_suen_thinning_subpass_core #(
      .MAX_WIDTH (FRAME_MAX_WIDTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   zs_subpass_checker #(
      .MAX_WIDTH (FRAME_MAX_WIDTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatches),
      .results_due     (results_due),
      .results_checked (results_checked),
      .pixels_removed  (pixels_removed),
      .frames_closed   (frames_closed)
   );

   initial begin
      forever #(HALF_PERIOD) clock = ~clock;
   end

   // Guard against a hung run: stop at a generous cycle limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d results outstanding", results_due);
         $display("zhang_suen_thinning_subpass_core_tb failed");
         $finish;
      end
   end

   // Receiver: note each result transfer at the rising edge, then act on it
   // at the falling edge by drawing a stall for the next result. One long
   // hold-off lets the core fill up and push back on its input.
   always @(posedge clock) begin
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_transfers++;
         // re-draw the idle mode now and then so some stretches run flat out
         if (rsp_transfers % 64 == 0) rsp_idle_on = ($urandom_range(0, 2) != 0);
         rsp_gap = (rsp_idle_on && !quiet_mode) ? $urandom_range(0, MAX_GAP) : 0;
         if (rsp_transfers == HOLD_AT) rsp_gap = LONG_HOLD;
      end
      if (rsp_gap != 0) begin
         rsp_tready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Write one register; returns at a falling edge with csr_valid already low.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one pixel after a random gap and hold it until the transfer.
   // Returns at a falling edge with req_tvalid still high, so a following
   // pixel with no gap goes out back to back.
   task automatic send_pixel(input logic pix, input logic is_flush);
      int gap;
      gap = (sender_idle_on && !quiet_mode) ? $urandom_range(0, MAX_GAP) : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, pix};
      req_tuser  <= is_flush;
      do @(posedge clock); while (!req_tready);
      in_transfers++;
      if (is_flush) flush_transfers++;
      @(negedge clock);
   endtask

   // Drop valid and hold off until every expected result has arrived, then
   // let the pipeline settle so a register write finds the core idle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic int effective_size(input int raw, input int hi);
      return (raw < 3) ? 3 : ((raw > hi) ? hi : raw);
   endfunction

   // One frame: program all registers, stream the pixels (random density or
   // a filled box with speckle), then width+1 trailing transfers that push
   // the last row out. Flush transfers inside the frame act as background;
   // non-flush pixels in the trailer only land in the line stores.
   task automatic send_frame(input int raw_w, input int raw_h, input logic rule,
                             input bit boxed);
      int   w;
      int   h;
      int   r;
      int   c;
      int   k;
      int   density;
      int   top_row;
      int   bottom_row;
      int   left_col;
      int   right_col;
      logic pix;
      logic is_flush;
      w = effective_size(raw_w, FRAME_MAX_WIDTH);
      h = effective_size(raw_h, MAX_HEIGHT);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(raw_w));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(raw_h));
      write_csr(CSR_SUBPASS_SELECT, CSR_DATA_W'(rule));
      sender_idle_on = ($urandom_range(0, 3) != 0);
      density    = $urandom_range(15, 85);
      top_row    = $urandom_range(0, h - 1);
      bottom_row = $urandom_range(top_row, h - 1);
      left_col   = $urandom_range(0, w - 1);
      right_col  = $urandom_range(left_col, w - 1);
      for (r = 0; r < h; r++) begin
         for (c = 0; c < w; c++) begin
            if (boxed) begin
               pix = (r >= top_row && r <= bottom_row && c >= left_col && c <= right_col)
                     ^ ($urandom_range(0, 31) == 0);
            end else begin
               pix = ($urandom_range(0, 99) < density);
            end
            is_flush = ($urandom_range(0, 15) == 0);
            if (is_flush) pix = 1'($urandom_range(0, 1));
            send_pixel(pix, is_flush);
         end
      end
      for (k = 0; k <= w; k++) begin
         is_flush = ($urandom_range(0, 7) != 0);
         send_pixel(1'($urandom_range(0, 1)), is_flush);
      end
      frames_sent++;
   endtask

   initial begin : stimulus
      logic [8:0] corner_pattern;
      logic [8:0] column_pattern;
      int         k;
      int         w;
      int         h;
      int         drain_cycles;
      // bit r*3+c is row r, column c of a 3x3 frame
      corner_pattern = 9'b000_011_011;   // centre deletable under the first rule
      column_pattern = 9'b011_011_011;   // centre deletable only under the first rule

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: spare index ignored, out-of-range sizes saturate to 3x3.
      // The flush on the last pixel carries a 1 that must read as background,
      // and the trailer starts with a real pixel that only reaches storage.
      write_csr(CSR_SPARE, '1);
      write_csr(CSR_IMAGE_WIDTH, '0);
      write_csr(CSR_IMAGE_HEIGHT, '0);
      write_csr(CSR_SUBPASS_SELECT, '0);
      for (k = 0; k < 9; k++) begin
         send_pixel(corner_pattern[k] | (k == 8), k == 8);
      end
      send_pixel(1'b1, 1'b0);
      repeat (3) send_pixel(1'b0, 1'b1);
      frames_sent++;

      // Same size, second rule: the column shape must survive.
      wait_idle();
      write_csr(CSR_SUBPASS_SELECT, CSR_DATA_W'(1));
      for (k = 0; k < 9; k++) begin
         send_pixel(column_pattern[k], 1'b0);
      end
      repeat (4) send_pixel(1'b1, 1'b1);
      frames_sent++;

      // Mid-size frame: the receiver's long hold-off falls well inside it,
      // so the core fills up while the sender keeps offering pixels. Then a
      // small frame run flat out with no idling on either side.
      send_frame(24, 6, 1'($urandom_range(0, 1)), 1'b1);
      quiet_mode = 1'b1;
      send_frame(12, 4, 1'($urandom_range(0, 1)), 1'b0);
      quiet_mode = 1'b0;

      // Random frames, mostly narrow and short
      while (random_items < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
         h = $urandom_range(3, 8);
         send_frame(w, h, 1'($urandom_range(0, 1)), ($urandom_range(0, 2) == 0));
         random_items += w * h + w + 1;
      end

      // Drain with a limit, then give stray results a chance to show up.
      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (results_due != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d frames, %0d input transfers (%0d flush), sizes 3x3 to 64 wide %s",
               frames_sent, in_transfers, flush_transfers,
               "and 8 tall, both rules, one long output stall");
      $display("checked %0d results, %0d pixels removed, %0d frame ends, %s",
               results_checked, pixels_removed, frames_closed, "totals below");
      $display("   %0d mismatches, %0d missing", mismatches, results_due);
      if (mismatches == 0 && results_due == 0) begin
         $display("zhang_suen_thinning_subpass_core_tb passed");
      end else begin
         $display("zhang_suen_thinning_subpass_core_tb failed");
      end
      $finish;
   end

endmodule
